### sv/nrp_pkg.sv
package nrp_pkg;

  localparam int MaxPacketBytes = 512;
  // Internal position arithmetic width: covers position + label skip + data length.
  localparam int CalcW = 20;
  localparam int FifoDepth = 4;

  localparam logic [16:0] PosMax = 17'h1FFFF;
  localparam logic [15:0] RespBit = 16'h8000;
  localparam logic [7:0] LabelPtr = 8'hC0;
  localparam logic [15:0] TypeNodeStat = 16'h0021;
  localparam logic [15:0] TypeAddr = 16'h0020;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [9:0] MinPacket = 10'd57;

  typedef enum logic [8:0] {
    PH_HEADER = 9'b000000001,
    PH_QLABEL = 9'b000000010,
    PH_ANAME  = 9'b000000100,
    PH_ALABEL = 9'b000001000,
    PH_FIXED  = 9'b000010000,
    PH_COUNT  = 9'b000100000,
    PH_ENTRY  = 9'b001000000,
    PH_ADDR   = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_ADDR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] host_address;
    logic [63:0] name_head;
    logic [55:0] name_tail;
    logic [3:0]  name_length;
    logic [7:0]  name_suffix;
    logic [15:0] entry_flags;
    logic [31:0] entry_address;
    logic [7:0]  names_in_record;
    logic        last_of_run;
  } result_t;

endpackage

### sv/nrp_if.sv
interface nrp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [9:0]  packet_length;
  logic [31:0] source_address;
  logic        last_byte;

  modport source(output valid, data_byte, packet_length, source_address, last_byte,
                 input ready);
  modport sink(input valid, data_byte, packet_length, source_address, last_byte,
               output ready);
endinterface

interface nrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] host_address;
  logic [63:0] name_head;
  logic [55:0] name_tail;
  logic [3:0]  name_length;
  logic [7:0]  name_suffix;
  logic [15:0] entry_flags;
  logic [31:0] entry_address;
  logic [7:0]  names_in_record;
  logic        last_of_run;

  modport source(output valid, result_kind, host_address, name_head, name_tail,
                 name_length, name_suffix, entry_flags, entry_address,
                 names_in_record, last_of_run, input ready);
  modport sink(input valid, result_kind, host_address, name_head, name_tail,
               name_length, name_suffix, entry_flags, entry_address,
               names_in_record, last_of_run, output ready);
endinterface

### sv/nbns_response_parser_top.sv
// Channel      | Dir | Payload
// -------------+-----+---------------------------------------------------------
// byte_in      | in  | data_byte, packet_length, source_address, last_byte
// result_out   | out | result_kind, host_address, name fields, flags, address,
//              |     | names_in_record, last_of_run
//
// One byte is accepted per clock while byte_in.ready is high; the parse step for a
// byte is combinational logic from the parser registers into a four-entry result queue.
// A byte produces zero, one or two results; the queue drains one per clock while
// result_out.ready is high, so byte_in.ready drops only when fewer than two
// queue slots are free. Reset (rst, synchronous) returns the parser to the
// header phase and empties the queue. A stall on result_out holds the queue head unchanged.
module nbns_response_parser_top import nrp_pkg::*; (
  input logic       clk,
  input logic       rst,
  nrp_in_if.sink    byte_in,
  nrp_out_if.source result_out
);

  typedef struct packed {
    phase_t      phase;
    logic [16:0] skip;
    logic [15:0] ansl;
  } step_t;

  typedef struct packed {
    step_t      s;
    logic [7:0] nl;
    logic       end_flag;
  } nsn_t;

  // Parser state
  logic [16:0] byte_position, byte_position_next;
  phase_t      parse_phase, parse_phase_next;
  logic [15:0] header_flags, header_flags_next;
  logic [15:0] answers_left, answers_left_next;
  logic [16:0] skip_target, skip_target_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] record_data_length, record_data_length_next;
  logic [16:0] record_data_end, record_data_end_next;
  logic [7:0]  names_left, names_left_next;
  logic [7:0]  names_emitted, names_emitted_next;
  logic [4:0]  entry_byte_index, entry_byte_index_next;
  logic [7:0]  name_bytes [15];
  logic [47:0] entry_word, entry_word_next;
  logic        nb_we;

  // Result queue
  result_t     res_q [FifoDepth];
  logic [1:0]  head, tail;
  logic [2:0]  count;
  logic        emit_name, emit_addr, emit_end;
  result_t     res0, res1;
  logic [1:0]  npush;
  logic        pop, accept;

  function automatic step_t enter_answer(logic [15:0] al, logic [CalcW-1:0] q,
                                         logic [CalcW-1:0] len, step_t cur);
    step_t s;
    s = cur;
    if (al == 16'd0 || q + CalcW'(12) > len) begin
      s.phase = PH_DONE;
    end else begin
      s.ansl = al - 16'd1;
      s.phase = PH_ANAME;
      s.skip = q[16:0];
    end
    return s;
  endfunction

  function automatic step_t after_qname(logic [CalcW-1:0] pos, logic [CalcW-1:0] len,
                                        step_t cur);
    step_t s;
    s = cur;
    if (pos + CalcW'(4) > len) s.phase = PH_DONE;
    else s = enter_answer(cur.ansl, pos + CalcW'(4), len, cur);
    return s;
  endfunction

  function automatic step_t qlabel(logic [CalcW-1:0] q, logic [CalcW-1:0] len,
                                   step_t cur);
    step_t s;
    s = cur;
    if (q >= len) begin
      s = after_qname(q + CalcW'(1), len, cur);
    end else begin
      s.phase = PH_QLABEL;
      s.skip = q[16:0];
    end
    return s;
  endfunction

  function automatic step_t after_aname(logic [CalcW-1:0] pos, logic [CalcW-1:0] len,
                                        step_t cur);
    step_t s;
    s = cur;
    if (pos + CalcW'(10) > len) begin
      s.phase = PH_DONE;
    end else begin
      s.phase = PH_FIXED;
      s.skip = pos[16:0];
    end
    return s;
  endfunction

  function automatic step_t alabel(logic [CalcW-1:0] q, logic [CalcW-1:0] len,
                                   step_t cur);
    step_t s;
    s = cur;
    if (q >= len) begin
      s = after_aname(q + CalcW'(1), len, cur);
    end else begin
      s.phase = PH_ALABEL;
      s.skip = q[16:0];
    end
    return s;
  endfunction

  // Next name entry of a node-status record, or close the record
  function automatic nsn_t ns_next(logic [7:0] nl, logic [CalcW-1:0] q,
                                   logic [16:0] rde, logic [CalcW-1:0] len,
                                   step_t cur);
    nsn_t r;
    r.s = cur;
    r.nl = nl;
    r.end_flag = 1'b0;
    if (nl != 8'd0 && q + CalcW'(18) <= CalcW'(rde)) begin
      r.nl = nl - 8'd1;
      r.s.phase = PH_ENTRY;
      r.s.skip = q[16:0];
    end else begin
      r.end_flag = 1'b1;
      r.s = enter_answer(cur.ansl, CalcW'(rde), len, cur);
    end
    return r;
  endfunction

  logic [CalcW-1:0] len_c, q_c, p_c;
  logic [3:0]       name_len;
  logic [63:0]      head_w;
  logic [55:0]      tail_w;

  always_comb begin
    step_t cur, s;
    nsn_t  nn;
    logic  stepped;
    logic [CalcW-1:0] pos;

    len_c = (byte_in.packet_length > 10'(MaxPacketBytes)) ? CalcW'(MaxPacketBytes)
                                                         : CalcW'(byte_in.packet_length);
    q_c = CalcW'(skip_target);
    p_c = CalcW'(byte_position);

    byte_position_next = (byte_position < PosMax) ? byte_position + 17'd1 : PosMax;
    parse_phase_next = parse_phase;
    header_flags_next = header_flags;
    answers_left_next = answers_left;
    skip_target_next = skip_target;
    record_type_next = record_type;
    record_data_length_next = record_data_length;
    record_data_end_next = record_data_end;
    names_left_next = names_left;
    names_emitted_next = names_emitted;
    entry_byte_index_next = entry_byte_index;
    entry_word_next = entry_word;
    nb_we = 1'b0;
    emit_name = 1'b0;
    emit_addr = 1'b0;
    emit_end = 1'b0;
    stepped = 1'b0;
    pos = '0;

    cur.phase = parse_phase;
    cur.skip = skip_target;
    cur.ansl = answers_left;
    s = cur;
    nn.s = cur;
    nn.nl = names_left;
    nn.end_flag = 1'b0;

    // Trimmed name length: one past the last non-space byte
    name_len = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (name_bytes[i] != SpaceChar) name_len = 4'(i + 1);
    end
    for (int i = 0; i < 8; i++) head_w[63 - 8*i -: 8] = name_bytes[i];
    for (int i = 0; i < 7; i++) tail_w[55 - 8*i -: 8] = name_bytes[8 + i];

    if (p_c < len_c) begin
      if (parse_phase == PH_HEADER) begin
        if (byte_position < 17'd12) begin
          if (byte_position == 17'd2 || byte_position == 17'd3)
            header_flags_next = {header_flags[7:0], byte_in.data_byte};
          if (byte_position == 17'd6 || byte_position == 17'd7)
            answers_left_next = {answers_left[7:0], byte_in.data_byte};
          if (byte_position == 17'd11) begin
            if (byte_in.packet_length < MinPacket || (header_flags & RespBit) == 16'd0
                || answers_left == 16'd0) begin
              parse_phase_next = PH_DONE;
            end else begin
              parse_phase_next = PH_QLABEL;
              skip_target_next = 17'd12;
            end
          end
        end
      end else if (parse_phase != PH_DONE && byte_position == skip_target) begin
        unique case (parse_phase)
          PH_QLABEL: begin
            stepped = 1'b1;
            if (skip_target == 17'd12 && byte_in.data_byte == SpaceChar)
              s = after_qname(CalcW'(46), len_c, cur);
            else if (byte_in.data_byte == 8'd0)
              s = after_qname(q_c + CalcW'(1), len_c, cur);
            else
              s = qlabel(q_c + CalcW'(byte_in.data_byte) + CalcW'(1), len_c, cur);
          end
          PH_ANAME: begin
            stepped = 1'b1;
            if (byte_in.data_byte == LabelPtr)
              s = after_aname(q_c + CalcW'(2), len_c, cur);
            else if (byte_in.data_byte == 8'd0)
              s = after_aname(q_c + CalcW'(1), len_c, cur);
            else
              s = alabel(q_c + CalcW'(byte_in.data_byte) + CalcW'(1), len_c, cur);
          end
          PH_ALABEL: begin
            stepped = 1'b1;
            if (byte_in.data_byte == 8'd0)
              s = after_aname(q_c + CalcW'(1), len_c, cur);
            else
              s = alabel(q_c + CalcW'(byte_in.data_byte) + CalcW'(1), len_c, cur);
          end
          PH_FIXED: begin
            if (entry_byte_index < 5'd2)
              record_type_next = {record_type[7:0], byte_in.data_byte};
            if (entry_byte_index >= 5'd8)
              record_data_length_next = {record_data_length[7:0], byte_in.data_byte};
            if (entry_byte_index >= 5'd9) begin
              stepped = 1'b1;
              pos = q_c + CalcW'(1);
              if (record_type_next == TypeNodeStat && record_data_length_next != 16'd0
                  && pos + CalcW'(record_data_length_next) <= len_c) begin
                record_data_end_next = 17'(pos + CalcW'(record_data_length_next));
                s.phase = PH_COUNT;
                s.skip = pos[16:0];
              end else if (record_type_next == TypeAddr
                           && record_data_length_next >= 16'd6
                           && pos + CalcW'(6) <= len_c) begin
                s.phase = PH_ADDR;
                s.skip = pos[16:0];
              end else begin
                s = enter_answer(answers_left, pos + CalcW'(record_data_length_next),
                                 len_c, cur);
              end
            end else begin
              entry_byte_index_next = entry_byte_index + 5'd1;
              skip_target_next = skip_target + 17'd1;
            end
          end
          PH_COUNT: begin
            stepped = 1'b1;
            names_emitted_next = 8'd0;
            nn = ns_next(byte_in.data_byte, q_c + CalcW'(1), record_data_end, len_c, cur);
            s = nn.s;
            names_left_next = nn.nl;
            emit_end = nn.end_flag;
          end
          PH_ENTRY: begin
            if (entry_byte_index < 5'd15) nb_we = 1'b1;
            else entry_word_next = {entry_word[39:0], byte_in.data_byte};
            if (entry_byte_index >= 5'd17) begin
              stepped = 1'b1;
              if (name_len != 4'd0 && name_bytes[0] != 8'd0) begin
                emit_name = 1'b1;
                names_emitted_next = names_emitted + 8'd1;
              end
              nn = ns_next(names_left, q_c + CalcW'(1), record_data_end, len_c, cur);
              s = nn.s;
              names_left_next = nn.nl;
              emit_end = nn.end_flag;
            end else begin
              entry_byte_index_next = entry_byte_index + 5'd1;
              skip_target_next = skip_target + 17'd1;
            end
          end
          PH_ADDR: begin
            entry_word_next = {entry_word[39:0], byte_in.data_byte};
            if (entry_byte_index >= 5'd5) begin
              stepped = 1'b1;
              emit_addr = 1'b1;
              s = enter_answer(answers_left, q_c + CalcW'(1), len_c, cur);
            end else begin
              entry_byte_index_next = entry_byte_index + 5'd1;
              skip_target_next = skip_target + 17'd1;
            end
          end
          default: begin
            stepped = 1'b1;
            s.phase = PH_DONE;
          end
        endcase
        if (stepped) begin
          parse_phase_next = s.phase;
          skip_target_next = s.skip;
          answers_left_next = s.ansl;
          // Each entry into a counted field run restarts the byte index
          if (s.phase == PH_FIXED || s.phase == PH_ENTRY || s.phase == PH_ADDR)
            entry_byte_index_next = 5'd0;
        end
      end
    end

    // Assemble results: a name entry may be followed by the record end
    res0 = '0;
    res1 = '0;
    res0.host_address = byte_in.source_address;
    res1.host_address = byte_in.source_address;
    res1.result_kind = KIND_END;
    res1.names_in_record = names_emitted_next;
    res1.last_of_run = 1'b1;
    if (emit_name) begin
      res0.result_kind = KIND_NAME;
      res0.name_head = head_w;
      res0.name_tail = tail_w;
      res0.name_length = name_len;
      res0.name_suffix = entry_word_next[23:16];
      res0.entry_flags = entry_word_next[15:0];
      res0.last_of_run = !emit_end;
    end else if (emit_addr) begin
      res0.result_kind = KIND_ADDR;
      res0.entry_flags = entry_word_next[47:32];
      res0.entry_address = entry_word_next[31:0];
      res0.last_of_run = 1'b1;
    end else begin
      res0 = res1;
    end
    npush = 2'(emit_name || emit_addr || emit_end) + 2'(emit_name && emit_end);
  end

  assign accept = byte_in.valid && byte_in.ready;
  assign pop = result_out.valid && result_out.ready;
  assign byte_in.ready = (count <= 3'(FifoDepth - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      parse_phase <= PH_HEADER;
      header_flags <= '0;
      answers_left <= '0;
      skip_target <= '0;
      record_type <= '0;
      record_data_length <= '0;
      record_data_end <= '0;
      names_left <= '0;
      names_emitted <= '0;
      entry_byte_index <= '0;
      entry_word <= '0;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        // Packet over: drop all parse state
        byte_position <= '0;
        parse_phase <= PH_HEADER;
        header_flags <= '0;
        answers_left <= '0;
        skip_target <= '0;
        record_type <= '0;
        record_data_length <= '0;
        record_data_end <= '0;
        names_left <= '0;
        names_emitted <= '0;
        entry_byte_index <= '0;
        entry_word <= '0;
      end else begin
        byte_position <= byte_position_next;
        parse_phase <= parse_phase_next;
        header_flags <= header_flags_next;
        answers_left <= answers_left_next;
        skip_target <= skip_target_next;
        record_type <= record_type_next;
        record_data_length <= record_data_length_next;
        record_data_end <= record_data_end_next;
        names_left <= names_left_next;
        names_emitted <= names_emitted_next;
        entry_byte_index <= entry_byte_index_next;
        entry_word <= entry_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nb_we) name_bytes[entry_byte_index[3:0]] <= byte_in.data_byte;
  end

  // Result queue: push up to two, pop one per transaction
  always_ff @(posedge clk) begin
    if (accept && npush != 2'd0) res_q[tail] <= res0;
    if (accept && npush == 2'd2) res_q[tail + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + 2'd1;
      if (accept) tail <= tail + npush;
      count <= count + (accept ? 3'(npush) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign result_out.valid = (count != 3'd0);
  assign result_out.result_kind = res_q[head].result_kind;
  assign result_out.host_address = res_q[head].host_address;
  assign result_out.name_head = res_q[head].name_head;
  assign result_out.name_tail = res_q[head].name_tail;
  assign result_out.name_length = res_q[head].name_length;
  assign result_out.name_suffix = res_q[head].name_suffix;
  assign result_out.entry_flags = res_q[head].entry_flags;
  assign result_out.entry_address = res_q[head].entry_address;
  assign result_out.names_in_record = res_q[head].names_in_record;
  assign result_out.last_of_run = res_q[head].last_of_run;

endmodule

### sv/nrp_checker.sv
module nrp_checker import nrp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_name_length,
  input logic [7:0]  out_names_in_record,
  input logic [31:0] out_entry_address
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped or changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind == KIND_NAME || out_kind == KIND_ADDR || out_kind == KIND_END)
    else $error("undefined result kind");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_NAME |-> out_name_length == 4'd0
      && (out_kind == KIND_END || out_names_in_record == 8'd0)
      && (out_kind == KIND_ADDR || out_entry_address == 32'd0))
    else $error("field set outside its result kind");

endmodule

bind nbns_response_parser_top nrp_checker u_nrp_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .out_kind(result_out.result_kind),
  .out_name_length(result_out.name_length),
  .out_names_in_record(result_out.names_in_record),
  .out_entry_address(result_out.entry_address)
);
